// ===== sv/kgst_pkg.sv =====
// shared types, codes and helpers of the key grid self-test sequencer
package kgst_pkg;

  // width of the cell vector that first_set searches, and the default grid size
  localparam int unsigned KGST_CELL_MAX   = 32;
  localparam int unsigned KGST_CELL_COUNT = 16;

  // item modes
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_KEY   = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;

  // verdict codes
  localparam logic [1:0] VERDICT_OK     = 2'd0;
  localparam logic [1:0] VERDICT_NO_KEY = 2'd1;
  localparam logic [1:0] VERDICT_STUCK  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_BOOT_STUCK   = 3'd0;
  localparam logic [2:0] CFG_FORCE_FULL   = 3'd1;
  localparam logic [2:0] CFG_STORED_MASK  = 3'd2;
  localparam logic [2:0] CFG_KEY_TIMEOUT  = 3'd3;
  localparam logic [2:0] CFG_PASS_LIMIT   = 3'd4;

  // configuration register reset values
  localparam logic [15:0] CFG_BOOT_STUCK_RST  = 16'h0000;
  localparam logic        CFG_FORCE_FULL_RST  = 1'b1;
  localparam logic [15:0] CFG_STORED_MASK_RST = 16'hFFFF;
  localparam logic [31:0] CFG_KEY_TIMEOUT_RST = 32'd10000000;
  localparam logic [3:0]  CFG_PASS_LIMIT_RST  = 4'd2;

  typedef struct packed {
    logic [15:0] boot_stuck_mask;
    logic        force_full_run;
    logic [15:0] stored_health_mask;
    logic [31:0] key_timeout_us;
    logic [3:0]  pass_limit;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  cell_req;
    logic [63:0] now_us;
  } item_t;

  typedef struct packed {
    logic        outcome_valid;
    logic [3:0]  outcome_cell;
    logic [1:0]  verdict;
    logic [3:0]  outcome_pass;
    logic [15:0] health_mask;
    logic        run_complete;
    logic [4:0]  lit_cell;
  } result_t;

  // lowest set bit of a cell vector, KGST_CELL_MAX when none is set
  function automatic logic [5:0] first_set(input logic [KGST_CELL_MAX-1:0] v);
    logic [5:0] idx;
    idx = 6'(KGST_CELL_MAX);
    for (int i = KGST_CELL_MAX - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = 6'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ===== sv/key_grid_self_test_sequencer_unit.sv =====
// Key grid self-test sequencer: a start item loads the health mask and lights the lowest
// healthy cell; key-down items on the lit cell pass it, tick items at or past the deadline
// condemn or retry it, and every item returns exactly one result carrying the verdict (if
// any), the health mask, the completion flag and the lit cell. One item is taken every
// clock while out_ready is high; each item passes through the input register, then the
// result register, where its result is held until out_ready takes it. While a result
// waits for out_ready the input register still takes one more item, after which in_ready
// stays low until the result is taken. The cycle is set by the next-cell priority encoder
// and the 64-bit deadline add and compare. Configuration must be written by the user
// through cfg_we/cfg_index/cfg_data while the block is idle (not enforced by the block).
module key_grid_self_test_sequencer_unit
  import kgst_pkg::*;
#(
  parameter int unsigned CELL_COUNT = KGST_CELL_COUNT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [3:0]  in_cell_req,
  input  logic [63:0] in_now_us,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_outcome_valid,
  output logic [3:0]  out_outcome_cell,
  output logic [1:0]  out_verdict,
  output logic [3:0]  out_outcome_pass,
  output logic [15:0] out_health_mask,
  output logic        out_run_complete,
  output logic [4:0]  out_lit_cell
);

  cfg_t    cfg;
  item_t   item_r;
  logic    item_vld_r;
  result_t res;
  result_t res_r;
  logic    res_vld_r;
  logic    go;

  kgst_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  kgst_seq #(
    .CELL_COUNT (CELL_COUNT)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .item    (item_r),
    .item_en (go),
    .result  (res)
  );

  // the held item is processed when the result register can take its result
  assign go       = item_vld_r && (!res_vld_r || out_ready);
  assign in_ready = !item_vld_r || go;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_ready) begin
      item_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.mode     <= in_mode;
      item_r.cell_req <= in_cell_req;
      item_r.now_us   <= in_now_us;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (go) begin
      res_vld_r <= 1'b1;
    end else if (out_ready) begin
      res_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      res_r <= res;
    end
  end

  assign out_valid         = res_vld_r;
  assign out_outcome_valid = res_r.outcome_valid;
  assign out_outcome_cell  = res_r.outcome_cell;
  assign out_verdict       = res_r.verdict;
  assign out_outcome_pass  = res_r.outcome_pass;
  assign out_health_mask   = res_r.health_mask;
  assign out_run_complete  = res_r.run_complete;
  assign out_lit_cell      = res_r.lit_cell;

endmodule

// ===== sv/kgst_cfg_regs.sv =====
// configuration register file of the key grid self-test sequencer
module kgst_cfg_regs
  import kgst_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output cfg_t        cfg
);

  cfg_t cfg_r;

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.boot_stuck_mask    <= CFG_BOOT_STUCK_RST;
      cfg_r.force_full_run     <= CFG_FORCE_FULL_RST;
      cfg_r.stored_health_mask <= CFG_STORED_MASK_RST;
      cfg_r.key_timeout_us     <= CFG_KEY_TIMEOUT_RST;
      cfg_r.pass_limit         <= CFG_PASS_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BOOT_STUCK:  cfg_r.boot_stuck_mask    <= cfg_data[15:0];
        CFG_FORCE_FULL:  cfg_r.force_full_run     <= cfg_data[0];
        CFG_STORED_MASK: cfg_r.stored_health_mask <= cfg_data[15:0];
        CFG_KEY_TIMEOUT: cfg_r.key_timeout_us     <= cfg_data;
        CFG_PASS_LIMIT:  cfg_r.pass_limit         <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== sv/kgst_seq.sv =====
// test state registers and the per-item next-state and result logic
module kgst_seq
  import kgst_pkg::*;
#(
  parameter int unsigned CELL_COUNT = KGST_CELL_COUNT
) (
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  item_t   item,
  input  logic    item_en,
  output result_t result
);

  localparam int unsigned IDX_W = $clog2(CELL_COUNT + 1);
  localparam logic [IDX_W-1:0] NO_CELL = IDX_W'(CELL_COUNT);
  localparam logic [CELL_COUNT-1:0] ALL_CELLS = '1;

  logic [CELL_COUNT-1:0] health_r, health_nxt;
  logic [CELL_COUNT-1:0] stuck_r, stuck_nxt;
  logic [CELL_COUNT-1:0] pending_r, pending_nxt;
  logic [CELL_COUNT-1:0] retry_r, retry_nxt;
  logic [3:0]            pass_r, pass_nxt;
  logic                  done_r, done_nxt;
  logic [IDX_W-1:0]      cur_r, cur_nxt;
  logic [63:0]           deadline_r, deadline_nxt;

  logic                  active;
  logic [CELL_COUNT-1:0] cur_bit;
  logic                  resolve;
  logic                  do_adv;
  logic [1:0]            verdict;
  logic [IDX_W-1:0]      start_idx;
  logic [CELL_COUNT-1:0] cand;
  logic [63:0]           new_deadline;

  assign active       = !done_r && (cur_r < NO_CELL);
  assign cur_bit      = (cur_r < NO_CELL) ? (ALL_CELLS & CELL_COUNT'(1)) << cur_r : '0;
  assign new_deadline = item.now_us + 64'(cfg.key_timeout_us);

  // item decode, verdict, then advance to the next pending cell, a retry pass or the end of the run
  always_comb begin
    health_nxt   = health_r;
    stuck_nxt    = stuck_r;
    pending_nxt  = pending_r;
    retry_nxt    = retry_r;
    pass_nxt     = pass_r;
    done_nxt     = done_r;
    cur_nxt      = cur_r;
    deadline_nxt = deadline_r;
    resolve      = 1'b0;
    do_adv       = 1'b0;
    verdict      = VERDICT_OK;
    start_idx    = '0;
    cand         = '0;
    result       = '0;

    unique case (item.mode)
      MODE_START: begin
        stuck_nxt   = CELL_COUNT'(cfg.boot_stuck_mask);
        health_nxt  = cfg.force_full_run ? ALL_CELLS : CELL_COUNT'(cfg.stored_health_mask);
        pending_nxt = health_nxt;
        retry_nxt   = '0;
        pass_nxt    = 4'd1;
        done_nxt    = 1'b0;
        cur_nxt     = NO_CELL;
        do_adv      = 1'b1;
      end
      MODE_KEY: begin
        if (active && (6'(item.cell_req) == 6'(cur_r))) begin
          stuck_nxt = stuck_r & ~cur_bit;
          verdict   = VERDICT_OK;
          resolve   = 1'b1;
        end
      end
      MODE_TICK: begin
        if (active && (item.now_us >= deadline_r)) begin
          verdict = ((stuck_r & cur_bit) != '0) ? VERDICT_STUCK : VERDICT_NO_KEY;
          resolve = 1'b1;
        end
      end
      default: ;
    endcase

    // verdict on the lit cell
    if (resolve) begin
      result.outcome_valid = 1'b1;
      result.outcome_cell  = 4'(cur_r);
      result.verdict       = verdict;
      result.outcome_pass  = pass_r;
      pending_nxt          = pending_r & ~cur_bit;
      unique case (verdict)
        VERDICT_OK: begin
          retry_nxt = retry_r & ~cur_bit;
        end
        VERDICT_STUCK: begin
          retry_nxt  = retry_r & ~cur_bit;
          health_nxt = health_r & ~cur_bit;
        end
        default: begin
          if (pass_r >= cfg.pass_limit) begin
            health_nxt = health_r & ~cur_bit;
          end else begin
            retry_nxt = retry_r | cur_bit;
          end
        end
      endcase
      do_adv = 1'b1;
    end

    // light the next pending cell, open a retry pass, or finish the run
    if (do_adv) begin
      start_idx = (cur_nxt >= NO_CELL) ? '0 : IDX_W'(cur_nxt + 1'b1);
      cand      = pending_nxt & (ALL_CELLS << start_idx);
      if (cand != '0) begin
        cur_nxt      = IDX_W'(first_set(KGST_CELL_MAX'(cand)));
        deadline_nxt = new_deadline;
      end else if ((retry_nxt != '0) && (pass_nxt < cfg.pass_limit)) begin
        pass_nxt     = 4'(pass_nxt + 4'd1);
        pending_nxt  = retry_nxt;
        retry_nxt    = '0;
        cur_nxt      = IDX_W'(first_set(KGST_CELL_MAX'(pending_nxt)));
        deadline_nxt = new_deadline;
      end else begin
        health_nxt = health_nxt & ~retry_nxt;
        cur_nxt    = NO_CELL;
        done_nxt   = 1'b1;
      end
    end

    result.health_mask  = 16'(health_nxt);
    result.run_complete = done_nxt;
    result.lit_cell     = 5'(cur_nxt);
  end

  // state update on each processed item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      health_r   <= ALL_CELLS;
      stuck_r    <= '0;
      pending_r  <= '0;
      retry_r    <= '0;
      pass_r     <= 4'd1;
      done_r     <= 1'b0;
      cur_r      <= NO_CELL;
      deadline_r <= '0;
    end else if (item_en) begin
      health_r   <= health_nxt;
      stuck_r    <= stuck_nxt;
      pending_r  <= pending_nxt;
      retry_r    <= retry_nxt;
      pass_r     <= pass_nxt;
      done_r     <= done_nxt;
      cur_r      <= cur_nxt;
      deadline_r <= deadline_nxt;
    end
  end

endmodule

// ===== verif/tb_key_grid_self_test_sequencer_unit.sv =====
// testbench for the key grid self-test sequencer: directed cases, pressure, random runs
`timescale 1ns / 1ps

module tb_key_grid_self_test_sequencer_unit;
  import kgst_pkg::*;

  localparam int         CELLS       = KGST_CELL_COUNT;
  localparam logic [4:0] NO_CELL     = 5'(KGST_CELL_COUNT);
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int         CYCLE_LIMIT = 300000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_mode = '0;
  logic [3:0]  in_cell_req = '0;
  logic [63:0] in_now_us = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_outcome_valid;
  logic [3:0]  out_outcome_cell;
  logic [1:0]  out_verdict;
  logic [3:0]  out_outcome_pass;
  logic [15:0] out_health_mask;
  logic        out_run_complete;
  logic [4:0]  out_lit_cell;

  key_grid_self_test_sequencer_unit DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mode           (in_mode),
    .in_cell_req       (in_cell_req),
    .in_now_us         (in_now_us),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_outcome_valid (out_outcome_valid),
    .out_outcome_cell  (out_outcome_cell),
    .out_verdict       (out_verdict),
    .out_outcome_pass  (out_outcome_pass),
    .out_health_mask   (out_health_mask),
    .out_run_complete  (out_run_complete),
    .out_lit_cell      (out_lit_cell)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor copy of the configuration registers
  logic [15:0] m_boot_stuck;
  logic        m_force_full;
  logic [15:0] m_stored_mask;
  logic [31:0] m_timeout;
  logic [3:0]  m_pass_limit;

  // predictor copy of the sequencer state
  logic [15:0] st_health;
  logic [15:0] st_stuck;
  logic [15:0] st_pending;
  logic [15:0] st_retry;
  logic [3:0]  st_pass;
  logic        st_done;
  logic [4:0]  st_lit;
  logic [63:0] st_deadline;

  result_t     grid_expect[$];
  logic [63:0] clk_us;
  int          n_sent;
  int          n_effective;
  int          n_checked;
  int          n_errors;
  int          n_verdict[3];
  int          cycle_count;
  bit          send_idle_en;
  bit          recv_idle_en;
  int          hold_token;
  int          hold_len;

  task automatic report_mismatch(input string msg);
    $display("error at result %0d: %s", n_checked, msg);
    n_errors++;
  endtask

  function automatic void grid_reset();
    m_boot_stuck  = CFG_BOOT_STUCK_RST;
    m_force_full  = CFG_FORCE_FULL_RST;
    m_stored_mask = CFG_STORED_MASK_RST;
    m_timeout     = CFG_KEY_TIMEOUT_RST;
    m_pass_limit  = CFG_PASS_LIMIT_RST;
    st_health     = 16'hFFFF;
    st_stuck      = '0;
    st_pending    = '0;
    st_retry      = '0;
    st_pass       = 4'd1;
    st_done       = 1'b0;
    st_lit        = NO_CELL;
    st_deadline   = '0;
  endfunction

  // light the lowest pending cell at or above from
  function automatic bit grid_light_from(input int from, input logic [63:0] now);
    for (int c = from; c < CELLS; c++) begin
      if (st_pending[c]) begin
        st_lit      = 5'(c);
        st_deadline = now + 64'(m_timeout);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // move on to the next cell, a new pass, or the end of the run
  function automatic void grid_advance(input logic [63:0] now);
    int from;
    from = (st_lit >= NO_CELL) ? 0 : int'(st_lit) + 1;
    if (grid_light_from(from, now)) return;
    if (st_retry != '0 && st_pass < m_pass_limit) begin
      st_pass    = st_pass + 4'd1;
      st_pending = st_retry;
      st_retry   = '0;
      st_lit     = NO_CELL;
      if (grid_light_from(0, now)) return;
    end
    st_health = st_health & ~st_retry;
    st_lit    = NO_CELL;
    st_done   = 1'b1;
  endfunction

  // settle the lit cell with verdict v
  function automatic result_t grid_resolve(input logic [1:0] v, input logic [63:0] now);
    result_t     r;
    logic [15:0] b;
    r               = '0;
    b               = 16'd1 << st_lit[3:0];
    r.outcome_valid = 1'b1;
    r.outcome_cell  = st_lit[3:0];
    r.verdict       = v;
    r.outcome_pass  = st_pass;
    st_pending      = st_pending & ~b;
    if (v == VERDICT_OK) begin
      st_retry = st_retry & ~b;
    end else if (v == VERDICT_STUCK) begin
      st_retry  = st_retry & ~b;
      st_health = st_health & ~b;
    end else if (st_pass >= m_pass_limit) begin
      st_health = st_health & ~b;
    end else begin
      st_retry = st_retry | b;
    end
    grid_advance(now);
    return r;
  endfunction

  // expected result of one accepted item, state updated as a side effect
  function automatic result_t grid_predict(input item_t it);
    result_t r;
    bit      active;
    r      = '0;
    active = !st_done && st_lit < NO_CELL;
    case (it.mode)
      MODE_START: begin
        st_stuck   = m_boot_stuck;
        st_health  = m_force_full ? 16'hFFFF : m_stored_mask;
        st_pending = st_health;
        st_retry   = '0;
        st_pass    = 4'd1;
        st_done    = 1'b0;
        st_lit     = NO_CELL;
        grid_advance(it.now_us);
      end
      MODE_KEY: begin
        if (active && {1'b0, it.cell_req} == st_lit) begin
          st_stuck[it.cell_req] = 1'b0;
          r = grid_resolve(VERDICT_OK, it.now_us);
        end
      end
      MODE_TICK: begin
        if (active && it.now_us >= st_deadline) begin
          r = grid_resolve(st_stuck[st_lit[3:0]] ? VERDICT_STUCK : VERDICT_NO_KEY, it.now_us);
        end
      end
      default: ;
    endcase
    r.health_mask  = st_health;
    r.run_complete = st_done;
    r.lit_cell     = st_lit;
    return r;
  endfunction

  // offer one item, wait for it to be taken, then record what it should produce
  task automatic send_item(input logic [1:0] mode, input logic [3:0] key_cell,
                           input logic [63:0] now);
    item_t   it;
    result_t r;
    if (send_idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_mode     <= mode;
    in_cell_req <= key_cell;
    in_now_us   <= now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    it.mode     = mode;
    it.cell_req = key_cell;
    it.now_us   = now;
    r           = grid_predict(it);
    grid_expect.push_back(r);
    n_sent++;
    if (mode == MODE_START || r.outcome_valid) n_effective++;
    if (r.outcome_valid) n_verdict[r.verdict]++;
    clk_us = now;
  endtask

  // stop offering and wait until every expected result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (grid_expect.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_BOOT_STUCK:  m_boot_stuck  = val[15:0];
      CFG_FORCE_FULL:  m_force_full  = val[0];
      CFG_STORED_MASK: m_stored_mask = val[15:0];
      CFG_KEY_TIMEOUT: m_timeout     = val;
      CFG_PASS_LIMIT:  m_pass_limit  = val[3:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [63:0] pick_start_time();
    case ($urandom_range(0, 3))
      0:       return 64'($urandom_range(0, 1000));
      1:       return 64'hFFFF_FFFF_FFFF_FF00 + 64'($urandom_range(0, 255));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [15:0] pick_mask();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // one item of a well-formed run, mostly presses and expired ticks on the lit cell
  task automatic grid_step();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      send_item(MODE_KEY, st_lit[3:0], clk_us + 64'($urandom_range(0, 3)));
    end else if (pick < 80) begin
      send_item(MODE_TICK, 4'($urandom), st_deadline + 64'($urandom_range(0, 2)));
    end else if (pick < 88) begin
      send_item(MODE_TICK, 4'($urandom), st_deadline - 64'd1);
    end else if (pick < 93) begin
      send_item(MODE_KEY, st_lit[3:0] ^ 4'($urandom_range(1, 15)), clk_us);
    end else if (pick < 97) begin
      send_item(MODE_UNUSED, 4'($urandom), {$urandom, $urandom});
    end else if (pick < 98) begin
      // pass limit changed in the middle of a run
      wait_drained();
      cfg_write(CFG_PASS_LIMIT, 32'($urandom_range(0, 15)));
    end else begin
      send_item(MODE_START, 4'($urandom), pick_start_time());
    end
  endtask

  // key and tick before any start, plus an unused mode
  task automatic test_idle_items();
    send_item(MODE_KEY, 4'd15, 64'd0);
    send_item(MODE_TICK, 4'd0, '1);
    send_item(MODE_UNUSED, 4'hA, 64'h5555_5555_AAAA_AAAA);
  endtask

  // reset configuration: wrong cell, good press, early tick, tick right at the deadline
  task automatic test_default_run();
    send_item(MODE_START, 4'd0, 64'd0);
    send_item(MODE_KEY, 4'd3, 64'd1);
    send_item(MODE_KEY, 4'd0, 64'd2);
    send_item(MODE_TICK, 4'd0, 64'd10000001);
    send_item(MODE_TICK, 4'd0, 64'd10000002);
  endtask

  // stuck cell, zero pass limit, zero timeout, then a tick after completion
  task automatic test_stuck_zero_limit();
    wait_drained();
    cfg_write(CFG_BOOT_STUCK, 32'h0001);
    cfg_write(CFG_FORCE_FULL, 32'd0);
    cfg_write(CFG_STORED_MASK, 32'h8003);
    cfg_write(CFG_KEY_TIMEOUT, 32'd0);
    cfg_write(CFG_PASS_LIMIT, 32'd0);
    send_item(MODE_START, 4'd0, '1);
    send_item(MODE_TICK, 4'd0, '1);
    send_item(MODE_TICK, 4'd0, '1);
    send_item(MODE_KEY, 4'd15, '1);
    send_item(MODE_TICK, 4'd15, '1);
  endtask

  // start with no healthy cell completes at once
  task automatic test_empty_mask();
    wait_drained();
    cfg_write(CFG_STORED_MASK, 32'h0000);
    send_item(MODE_START, 4'd5, 64'd42);
    send_item(MODE_KEY, 4'd0, 64'd43);
  endtask

  // largest timeout from a start near the top of time, deadline wraps
  task automatic test_deadline_wrap();
    wait_drained();
    cfg_write(CFG_BOOT_STUCK, 32'hFFFF);
    cfg_write(CFG_FORCE_FULL, 32'd1);
    cfg_write(CFG_KEY_TIMEOUT, 32'hFFFF_FFFF);
    cfg_write(CFG_PASS_LIMIT, 32'd15);
    send_item(MODE_START, 4'd0, 64'hFFFF_FFFF_FFFF_FFF0);
    send_item(MODE_TICK, 4'd0, 64'd0);
    send_item(MODE_TICK, 4'd0, 64'h0000_0000_FFFF_FFEF);
    send_item(MODE_KEY, 4'd1, 64'h0000_0000_FFFF_FFEF);
  endtask

  // no-key retry, then the limit is lowered to the current pass
  task automatic test_limit_lowered();
    wait_drained();
    cfg_write(CFG_BOOT_STUCK, 32'h0000);
    cfg_write(CFG_KEY_TIMEOUT, 32'd1);
    send_item(MODE_START, 4'd0, 64'd100);
    send_item(MODE_TICK, 4'd0, 64'd101);
    wait_drained();
    cfg_write(CFG_PASS_LIMIT, 32'd1);
    send_item(MODE_TICK, 4'd0, 64'd102);
  endtask

  // receiver holds off for a long stretch while items keep coming
  task automatic test_backpressure();
    wait_drained();
    cfg_write(CFG_FORCE_FULL, 32'd1);
    cfg_write(CFG_KEY_TIMEOUT, 32'd3);
    cfg_write(CFG_PASS_LIMIT, 32'd3);
    send_idle_en = 1'b0;
    recv_idle_en = 1'b0;
    hold_len     = 200;
    hold_token++;
    send_item(MODE_START, 4'd0, pick_start_time());
    repeat (40) begin
      if (st_done || st_lit == NO_CELL) send_item(MODE_START, 4'd0, pick_start_time());
      else grid_step();
    end
    // sender pauses until every result is back
    wait_drained();
  endtask

  // random runs under random configurations
  task automatic test_random_runs(input int target, input bit with_idle);
    send_idle_en = with_idle;
    recv_idle_en = with_idle;
    while (n_sent < target) begin
      if (st_done || st_lit == NO_CELL) begin
        if ($urandom_range(0, 3) == 0) begin
          send_item($urandom_range(0, 1) ? MODE_KEY : MODE_TICK, 4'($urandom),
                    {$urandom, $urandom});
        end
        if ($urandom_range(0, 1) == 0) begin
          wait_drained();
          cfg_write(CFG_BOOT_STUCK, 32'(pick_mask()));
          cfg_write(CFG_FORCE_FULL, 32'($urandom_range(0, 1)));
          cfg_write(CFG_STORED_MASK, 32'(pick_mask()));
          case ($urandom_range(0, 7))
            0:       cfg_write(CFG_KEY_TIMEOUT, $urandom);
            1:       cfg_write(CFG_KEY_TIMEOUT, 32'hFFFF_FFFF);
            default: cfg_write(CFG_KEY_TIMEOUT, 32'($urandom_range(0, 40)));
          endcase
          case ($urandom_range(0, 7))
            0:       cfg_write(CFG_PASS_LIMIT, 32'd0);
            1:       cfg_write(CFG_PASS_LIMIT, 32'd15);
            default: cfg_write(CFG_PASS_LIMIT, 32'($urandom_range(1, 4)));
          endcase
        end
        send_item(MODE_START, 4'($urandom), pick_start_time());
      end else begin
        grid_step();
      end
    end
  endtask

  // receiver: random stall bursts plus the requested long hold-off
  int hold_seen = 0;
  int hold_left = 0;
  int stall_left = 0;
  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = hold_len;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (recv_idle_en && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 13);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) report_mismatch($sformatf("%s expected %0h got %0h", name, want, got));
  endtask

  // compare each result with the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (grid_expect.size() == 0) begin
        report_mismatch("result with no item outstanding");
      end else begin
        want = grid_expect.pop_front();
        check_field("outcome_valid", 16'(want.outcome_valid), 16'(out_outcome_valid));
        check_field("outcome_cell", 16'(want.outcome_cell), 16'(out_outcome_cell));
        check_field("verdict", 16'(want.verdict), 16'(out_verdict));
        check_field("outcome_pass", 16'(want.outcome_pass), 16'(out_outcome_pass));
        check_field("health_mask", want.health_mask, out_health_mask);
        check_field("run_complete", 16'(want.run_complete), 16'(out_run_complete));
        check_field("lit_cell", 16'(want.lit_cell), 16'(out_lit_cell));
      end
      n_checked++;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               grid_expect.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    n_sent       = 0;
    n_effective  = 0;
    n_checked    = 0;
    n_errors     = 0;
    n_verdict    = '{0, 0, 0};
    cycle_count  = 0;
    hold_token   = 0;
    hold_len     = 0;
    clk_us       = '0;
    send_idle_en = 1'b0;
    recv_idle_en = 1'b0;
    grid_reset();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_items();
    test_default_run();
    test_stuck_zero_limit();
    test_empty_mask();
    test_deadline_wrap();
    test_limit_lowered();
    test_backpressure();
    test_random_runs(820, 1'b1);
    test_random_runs(1050, 1'b0);
    wait_drained();
    repeat (6) @(posedge clk);

    $display("run covered %0d items, %0d of them started or settled a cell, %0d results checked",
             n_sent, n_effective, n_checked);
    $display("verdicts seen: %0d ok, %0d no key, %0d stuck", n_verdict[VERDICT_OK],
             n_verdict[VERDICT_NO_KEY], n_verdict[VERDICT_STUCK]);
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== key_grid_self_test_sequencer_unit.f =====
sv/kgst_pkg.sv
sv/kgst_cfg_regs.sv
sv/kgst_seq.sv
sv/key_grid_self_test_sequencer_unit.sv
verif/tb_key_grid_self_test_sequencer_unit.sv
